// File: hw/rtl/fadc_bib_pkg.sv
// shared types and constants for the digitizer block island builder
// no dependencies; imported by the front, queue, back and top modules
`timescale 1ns / 1ps

package fadc_bib_pkg;

  // raw digitizer block width on the input stream
  localparam int BLOCK_W = 80;
  // samples per block and channel number width
  localparam int SLOTS = 4;
  localparam int CHAN_W = 3;

  // what the back end has to emit for one queued job
  typedef struct packed {
    logic emit_a;   // held-back block from before this item
    logic first_a;  // its first sample opens an island
    logic last_a;   // its last sample closes the island
    logic emit_b;   // block of this item, flushed at end of bank
  } job_flags_t;

endpackage

// File: hw/rtl/fadc_bib_front.sv
// front end: takes blocks, tracks island state and decides what is emitted
// depends on fadc_bib_pkg; feeds jobs into fadc_bib_queue
`timescale 1ns / 1ps

module fadc_bib_front
  import fadc_bib_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 12,
  parameter int TIME_WIDTH = 27
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [BLOCK_W-1:0] in_block,
  input  logic in_eob,
  output logic job_push,
  input  logic job_ready,
  output logic [4*(SAMPLE_WIDTH+1)-1:0] job_blk_a,
  output logic [4*(SAMPLE_WIDTH+1)-1:0] job_blk_b,
  output logic [TIME_WIDTH+1:0] job_time,
  output job_flags_t job_flags
);

  localparam int SLOT_W = SAMPLE_WIDTH + 1;
  localparam int BLK_W = SLOTS * SLOT_W;
  localparam int OVF_POS = SLOTS * SAMPLE_WIDTH;
  localparam int TS_POS = OVF_POS + SLOTS;
  localparam int FULL_W = (TS_POS + TIME_WIDTH > BLOCK_W) ? TS_POS + TIME_WIDTH : BLOCK_W;

  logic [FULL_W-1:0] blk_full;
  logic [TIME_WIDTH-1:0] ts;
  logic [BLK_W-1:0] blk_new;

  logic [BLK_W-1:0] pend_blk;
  logic pend_valid;
  logic confirmed;
  logic [TIME_WIDTH-1:0] island_start;
  logic [TIME_WIDTH-1:0] prev_time;
  logic bank_started;

  logic accept;
  logic cont;
  logic emit_a;
  logic emit_b;

  assign blk_full = FULL_W'(in_block);
  assign ts = blk_full[TS_POS +: TIME_WIDTH];

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      blk_new[k*SLOT_W +: SLOT_W] = {blk_full[OVF_POS + k], blk_full[k*SAMPLE_WIDTH +: SAMPLE_WIDTH]};
    end
  end

  // continuation compared one bit wider so the top timestamp never wraps to zero
  assign cont = bank_started && pend_valid &&
                ({1'b0, ts} == ({1'b0, prev_time} + (TIME_WIDTH+1)'(1)));
  assign emit_a = cont || (pend_valid && confirmed);
  assign emit_b = in_eob && cont;

  assign in_ready = job_ready;
  assign accept = in_valid && in_ready;

  assign job_push = accept && (emit_a || emit_b);
  assign job_blk_a = pend_blk;
  assign job_blk_b = blk_new;
  assign job_time = {island_start, 2'b00};
  assign job_flags = '{emit_a: emit_a, first_a: cont && !confirmed, last_a: !cont, emit_b: emit_b};

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_blk <= blk_new;
      prev_time <= ts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      confirmed <= 1'b0;
      island_start <= '0;
      bank_started <= 1'b0;
    end else if (accept) begin
      if (!cont) begin
        island_start <= ts;
      end
      if (in_eob) begin
        pend_valid <= 1'b0;
        confirmed <= 1'b0;
        bank_started <= 1'b0;
      end else begin
        pend_valid <= 1'b1;
        confirmed <= cont;
        bank_started <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/fadc_bib_queue.sv
// two-entry job queue between front and back end
// depends on fadc_bib_pkg for the shared import style only
`timescale 1ns / 1ps

module fadc_bib_queue
  import fadc_bib_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic head_valid,
  input  logic pop,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/fadc_bib_back.sv
// back end: walks the samples of each queued job into the output register
// depends on fadc_bib_pkg; reads jobs from fadc_bib_queue
`timescale 1ns / 1ps

module fadc_bib_back
  import fadc_bib_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 12,
  parameter int TIME_WIDTH = 27
) (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  output logic pop,
  input  logic [4*(SAMPLE_WIDTH+1)-1:0] head_blk_a,
  input  logic [4*(SAMPLE_WIDTH+1)-1:0] head_blk_b,
  input  logic [TIME_WIDTH+1:0] head_time,
  input  job_flags_t head_flags,
  input  logic [CHAN_W-1:0] channel,
  output logic out_valid,
  input  logic out_ready,
  output logic [TIME_WIDTH+1:0] out_time,
  output logic [SAMPLE_WIDTH-1:0] out_sample,
  output logic out_overflow,
  output logic [CHAN_W-1:0] out_channel,
  output logic out_first,
  output logic out_island_last,
  output logic out_last
);

  localparam int SLOT_W = SAMPLE_WIDTH + 1;
  localparam int BLK_W = SLOTS * SLOT_W;

  logic [2:0] pos;
  logic [1:0] slot;
  logic half;
  logic final_smp;
  logic load;
  logic [BLK_W-1:0] blk;
  logic [SLOT_W-1:0] smp;

  // half selects the end-of-bank block; jobs without the held-back block start there
  assign slot = pos[1:0];
  assign half = pos[2] || !head_flags.emit_a;
  assign final_smp = (head_flags.emit_a && head_flags.emit_b) ? (pos == 3'd7) : (slot == 2'd3);
  assign blk = half ? head_blk_b : head_blk_a;
  assign smp = blk[slot*SLOT_W +: SLOT_W];

  assign load = head_valid && (!out_valid || out_ready);
  assign pop = load && final_smp;

  always_ff @(posedge clk) begin
    if (load) begin
      out_time <= head_time;
      out_sample <= smp[SAMPLE_WIDTH-1:0];
      out_overflow <= smp[SAMPLE_WIDTH];
      out_channel <= channel;
      out_first <= !half && head_flags.first_a && (slot == 2'd0);
      out_island_last <= (slot == 2'd3) && (half || head_flags.last_a);
      out_last <= final_smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        out_valid <= head_valid;
      end
      if (load) begin
        pos <= final_smp ? 3'd0 : pos + 3'd1;
      end
    end
  end

endmodule

// File: hw/rtl/fadc_block_island_builder_top.sv
// Digitizer block island builder, top level.
//
// s_* takes one 80-bit block per transfer, s_tlast marks the last block of a
// bank and flushes the open island after it. m_* returns one sample per
// transfer with island start time, channel and island first/last marks in
// m_tuser; m_tlast marks the final sample caused by one input block.
// cfg_* writes the channel number; it is always ready. The user must make sure it
// is only written while the block is idle; the block itself does not enforce this.
// Each block gives 0, 4 or 8 samples. The newest block of an island is held
// back until the next block shows whether the island goes on, so samples
// appear one block later. The first sample passes through the job queue and the
// output register after the transfer that releases it; the output runs at one
// sample per cycle while m_tready is high, limited by the single-sample result channel.
// A two-entry job queue sits between the front end and the output stage, so
// input keeps being taken while samples drain. When m_tready is low the output
// register holds, the queue fills and s_tready drops.
// Reset clears all island state and the channel; the first block afterwards
// starts a new island.
`timescale 1ns / 1ps

module fadc_block_island_builder_top
  import fadc_bib_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 12,
  parameter int TIME_WIDTH = 27
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [BLOCK_W-1:0] s_tdata,  // block_high[15:0], block_low[79:16]
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // island_time, sample_value, sample_overflow, channel_out, zero fill
  output logic [((TIME_WIDTH+2+SAMPLE_WIDTH+1+CHAN_W)+7)/8*8-1:0] m_tdata,
  output logic [1:0] m_tuser,  // island_first, island_last
  output logic m_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CHAN_W-1:0] cfg_data
);

  localparam int BLK_W = SLOTS * (SAMPLE_WIDTH + 1);
  localparam int T_W = TIME_WIDTH + 2;
  localparam int FLAG_W = $bits(job_flags_t);
  localparam int JOB_W = 2 * BLK_W + T_W + FLAG_W;
  localparam int DATA_W = T_W + SAMPLE_WIDTH + 1 + CHAN_W;
  localparam int OUT_W = (DATA_W + 7) / 8 * 8;

  logic [CHAN_W-1:0] channel;

  logic job_push;
  logic job_ready;
  logic [BLK_W-1:0] job_blk_a;
  logic [BLK_W-1:0] job_blk_b;
  logic [T_W-1:0] job_time;
  job_flags_t job_flags;

  logic head_valid;
  logic pop;
  logic [JOB_W-1:0] head_data;

  logic [T_W-1:0] out_time;
  logic [SAMPLE_WIDTH-1:0] out_sample;
  logic out_overflow;
  logic [CHAN_W-1:0] out_channel;
  logic out_first;
  logic out_island_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= '0;
    end else if (cfg_valid && cfg_ready) begin
      channel <= cfg_data;
    end
  end

  fadc_bib_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_block({s_tdata[15:0], s_tdata[79:16]}),
    .in_eob(s_tlast),
    .job_push(job_push),
    .job_ready(job_ready),
    .job_blk_a(job_blk_a),
    .job_blk_b(job_blk_b),
    .job_time(job_time),
    .job_flags(job_flags)
  );

  fadc_bib_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .push_ready(job_ready),
    .push_data({job_flags, job_time, job_blk_b, job_blk_a}),
    .head_valid(head_valid),
    .pop(pop),
    .head_data(head_data)
  );

  fadc_bib_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .pop(pop),
    .head_blk_a(head_data[BLK_W-1:0]),
    .head_blk_b(head_data[2*BLK_W-1:BLK_W]),
    .head_time(head_data[2*BLK_W +: T_W]),
    .head_flags(job_flags_t'(head_data[JOB_W-1 -: FLAG_W])),
    .channel(channel),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_time(out_time),
    .out_sample(out_sample),
    .out_overflow(out_overflow),
    .out_channel(out_channel),
    .out_first(out_first),
    .out_island_last(out_island_last),
    .out_last(m_tlast)
  );

  assign m_tdata = OUT_W'({out_channel, out_overflow, out_sample, out_time});
  assign m_tuser = {out_island_last, out_first};

endmodule
